/* rtl/core/lcsf_pkg.sv */
// Shared widths, constants and stage payload types for the loop current
// setpoint filter. No dependencies; used by lcsf_scale and the top level.
package lcsf_pkg;

  // Field and register widths
  localparam int SAMPLE_W      = 16;
  localparam int GAIN_W        = 24;
  localparam int FRAC_W        = 16;
  localparam int PROD_W        = SAMPLE_W + GAIN_W;
  localparam int RESULT_W      = 16;
  localparam int CFG_ADDR_W    = 8;
  localparam int CFG_DATA_W    = 24;
  localparam int HISTORY_DEPTH = 4;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_ZERO_OFFSET = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN        = 8'd1;

  // Configuration reset values
  localparam logic [SAMPLE_W-1:0] ZERO_OFFSET_RESET = 16'd0;
  localparam logic [GAIN_W-1:0]   GAIN_RESET        = 24'd65536;

  // Trend detection step, in counts
  localparam logic [SAMPLE_W:0] TREND_STEP = 17'd5;

  // Result limits and dead-band edges
  localparam logic signed [RESULT_W-1:0] RESULT_MAX      = 16'sd32767;
  localparam logic signed [RESULT_W-1:0] RESULT_MIN      = -16'sd32768;
  localparam logic signed [RESULT_W-1:0] TOP_CLAMP_LOW   = 16'sd1000;
  localparam logic signed [RESULT_W-1:0] TOP_CLAMP_HIGH  = 16'sd1190;
  localparam logic signed [RESULT_W-1:0] ZERO_CLAMP_HIGH = 16'sd10;
  localparam logic signed [RESULT_W-1:0] ZERO_CLAMP_LOW  = -16'sd52;
  localparam logic signed [RESULT_W-1:0] LOSS_LIMIT      = -16'sd135;

  // Filtered count relative to the zero point, sign and magnitude
  typedef struct packed {
    logic                trend_bypass;
    logic                neg;
    logic [SAMPLE_W-1:0] mag;
  } scale_req_t;

  // Result flags, over_range in the lowest bit
  typedef struct packed {
    logic trend_bypass;
    logic signal_lost;
    logic over_range;
  } result_flags_t;

endpackage

/* rtl/core/lcsf_scale.sv */
// Gain multiply, saturation, dead-band clamp and fault flags.
// Two register stages with backpressure; depends on lcsf_pkg.
module lcsf_scale (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  lcsf_pkg::scale_req_t                req,
  input  logic [lcsf_pkg::GAIN_W-1:0]         gain,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [lcsf_pkg::RESULT_W-1:0] setpoint,
  output lcsf_pkg::result_flags_t             flags
);

  logic                              prod_valid;
  logic [lcsf_pkg::PROD_W-1:0]       prod;
  logic                              prod_neg;
  logic                              prod_bypass;
  logic                              out_free;
  logic                              prod_free;
  logic [lcsf_pkg::PROD_W-lcsf_pkg::FRAC_W-1:0] shifted;
  logic signed [lcsf_pkg::RESULT_W-1:0] sat;
  logic signed [lcsf_pkg::RESULT_W-1:0] clamped;
  logic                              over_range;
  logic                              signal_lost;

  // Each stage loads when empty or when its content moves on
  assign out_free  = !out_valid || out_ready;
  assign prod_free = !prod_valid || out_free;
  assign in_ready  = prod_free;

  // Multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (prod_free) begin
      prod_valid <= in_valid;
    end
    if (prod_free && in_valid) begin
      prod        <= {{lcsf_pkg::GAIN_W{1'b0}}, req.mag} *
                     {{lcsf_pkg::SAMPLE_W{1'b0}}, gain};
      prod_neg    <= req.neg;
      prod_bypass <= req.trend_bypass;
    end
  end

  // Truncate toward zero, restore sign, saturate
  assign shifted = prod[lcsf_pkg::PROD_W-1:lcsf_pkg::FRAC_W];

  always_comb begin
    if (!prod_neg) begin
      if (shifted >= 24'd32767) begin
        sat = lcsf_pkg::RESULT_MAX;
      end else begin
        sat = shifted[lcsf_pkg::RESULT_W-1:0];
      end
    end else begin
      if (shifted >= 24'd32768) begin
        sat = lcsf_pkg::RESULT_MIN;
      end else begin
        sat = -$signed(shifted[lcsf_pkg::RESULT_W-1:0]);
      end
    end
  end

  // Dead-band clamps, then fault flags from the final value
  always_comb begin
    clamped = sat;
    if (clamped > lcsf_pkg::TOP_CLAMP_LOW && clamped < lcsf_pkg::TOP_CLAMP_HIGH) begin
      clamped = lcsf_pkg::TOP_CLAMP_LOW;
    end
    if (clamped < lcsf_pkg::ZERO_CLAMP_HIGH && clamped > lcsf_pkg::ZERO_CLAMP_LOW) begin
      clamped = '0;
    end
    over_range  = (clamped > lcsf_pkg::TOP_CLAMP_HIGH) ||
                  (clamped >= lcsf_pkg::LOSS_LIMIT && clamped < lcsf_pkg::ZERO_CLAMP_LOW);
    signal_lost = clamped < lcsf_pkg::LOSS_LIMIT;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= prod_valid;
    end
    if (out_free && prod_valid) begin
      setpoint           <= clamped;
      flags.over_range   <= over_range;
      flags.signal_lost  <= signal_lost;
      flags.trend_bypass <= prod_bypass;
    end
  end

endmodule

/* rtl/core/loop_current_setpoint_filter.sv */
// Top level of the loop current setpoint filter: sample history, trend
// detection, averaging and configuration. Depends on lcsf_pkg, lcsf_scale.
//
// Takes one converter count per transaction and returns one setpoint per
// transaction. A new sample is accepted in every cycle unless the result side
// stalls; the filter register loads on the accepting edge, then the gain
// multiply and result registers load in turn. The four-entry history updates
// on accept, so results follow input order exactly. Stalls on the result side
// hold the whole pipeline. Configuration writes are accepted in every cycle;
// zero offset applies to samples accepted afterwards and gain to samples
// not yet multiplied; write them while the pipeline is empty.
module loop_current_setpoint_filter #(
  parameter int HISTORY_DEPTH = lcsf_pkg::HISTORY_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  // Input samples
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [15:0]                        s_tdata,  // [15:0] sample_count
  // Results
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [15:0]                        m_tdata,  // [15:0] setpoint
  output logic [2:0]                         m_tuser,  // [0] over_range,
                                                       // [1] signal_lost,
                                                       // [2] trend_bypass
  // Configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lcsf_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [lcsf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [lcsf_pkg::SAMPLE_W-1:0] history [HISTORY_DEPTH];
  logic [lcsf_pkg::SAMPLE_W-1:0] zero_offset;
  logic [lcsf_pkg::GAIN_W-1:0]   gain;

  logic                          s_accept;
  logic                          filt_valid;
  logic                          filt_free;
  logic                          scale_ready;
  lcsf_pkg::scale_req_t          filt;
  lcsf_pkg::scale_req_t          filt_next;

  logic [lcsf_pkg::SAMPLE_W:0]   h0;
  logic [lcsf_pkg::SAMPLE_W:0]   h1;
  logic [lcsf_pkg::SAMPLE_W:0]   h2;
  logic                          rising;
  logic                          falling;
  logic [lcsf_pkg::SAMPLE_W+1:0] sum;
  logic [lcsf_pkg::SAMPLE_W-1:0] chosen;

  logic signed [lcsf_pkg::RESULT_W-1:0] setpoint;
  lcsf_pkg::result_flags_t       flags;

  // Configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_offset <= lcsf_pkg::ZERO_OFFSET_RESET;
      gain        <= lcsf_pkg::GAIN_RESET;
    end else if (cfg_valid) begin
      case (cfg_addr)
        lcsf_pkg::REG_ZERO_OFFSET: zero_offset <= cfg_data[lcsf_pkg::SAMPLE_W-1:0];
        lcsf_pkg::REG_GAIN:        gain        <= cfg_data[lcsf_pkg::GAIN_W-1:0];
        default:                   ;
      endcase
    end
  end

  // Filter stage loads when empty or when its content moves on
  assign filt_free = !filt_valid || scale_ready;
  assign s_tready  = filt_free;
  assign s_accept  = s_tvalid && s_tready;

  // Shift the new sample into the history
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        history[i] <= '0;
      end
    end else if (s_accept) begin
      history[0] <= s_tdata;
      for (int i = 1; i < HISTORY_DEPTH; i++) begin
        history[i] <= history[i-1];
      end
    end
  end

  // Trend test on the three newest samples, including the incoming one
  assign h0 = {1'b0, s_tdata};
  assign h1 = {1'b0, history[0]};
  assign h2 = {1'b0, history[1]};
  assign rising  = (h0 > h1 + lcsf_pkg::TREND_STEP) && (h1 > h2 + lcsf_pkg::TREND_STEP);
  assign falling = (h1 > h0 + lcsf_pkg::TREND_STEP) && (h2 > h1 + lcsf_pkg::TREND_STEP);

  // Truncated mean of the four newest samples
  assign sum = {2'b00, s_tdata} + {2'b00, history[0]} +
               {2'b00, history[1]} + {2'b00, history[2]};

  always_comb begin
    filt_next.trend_bypass = rising || falling;
    chosen = filt_next.trend_bypass ? s_tdata : sum[lcsf_pkg::SAMPLE_W+1:2];
    filt_next.neg = chosen < zero_offset;
    filt_next.mag = filt_next.neg ? (zero_offset - chosen) : (chosen - zero_offset);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filt_valid <= 1'b0;
    end else if (filt_free) begin
      filt_valid <= s_tvalid;
    end
    if (s_accept) begin
      filt <= filt_next;
    end
  end

  // Scale, clamp and flag
  lcsf_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (filt_valid),
    .in_ready  (scale_ready),
    .req       (filt),
    .gain      (gain),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .setpoint  (setpoint),
    .flags     (flags)
  );

  assign m_tdata = setpoint;
  assign m_tuser = flags;

  // The pipeline can only hold off input while a result is pending
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with no result pending");

  // Fault flags exclude each other
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("over_range and signal_lost both set");

  // No result falls inside a dead band
  a_dead_bands: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |->
      !($signed(m_tdata) > lcsf_pkg::TOP_CLAMP_LOW &&
        $signed(m_tdata) < lcsf_pkg::TOP_CLAMP_HIGH) &&
      !($signed(m_tdata) < lcsf_pkg::ZERO_CLAMP_HIGH &&
        $signed(m_tdata) > lcsf_pkg::ZERO_CLAMP_LOW && m_tdata != 16'd0))
    else $error("setpoint inside a dead band");

endmodule
